### design/hscf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hscf_pkg;

   localparam int POS_W    = 22;
   localparam int DV_W     = 23;
   localparam int RAD_W    = 20;
   localparam int K_W      = 18;
   localparam int LIM_W    = 18;
   localparam int FORCE_W  = 19;
   localparam int SQ_W     = 46;
   localparam int ROOT_W   = 23;
   localparam int SREM_W   = 26;
   localparam int BASE_W   = 22;
   localparam int E_W      = 25;
   localparam int KE_W     = 43;
   localparam int MSEL_W   = 28;
   localparam int NUM_W    = 51;
   localparam int DEN_W    = 33;
   localparam int DREM_W   = 34;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;
   localparam int CNT_W    = 6;

   localparam int SQRT_STEPS = 23;
   localparam int DIV_STEPS  = 51;
   localparam int MN_PER_UN  = 1000;

   localparam logic [CSR_IDX_W-1:0] REG_BIAS_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_Z        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPHERE_RADIUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CURSOR_RADIUS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STIFFNESS     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_LIMIT   = 3'd6;

   typedef struct packed {
      logic load_in;
      logic square;
      logic sum;
      logic sqrt_step;
      logic eval;
      logic ke;
      logic cmp;
      logic num;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic zero_force;
   } status_type;

endpackage
`default_nettype wire

### design/hscf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hscf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output hscf_pkg::cmd_type        cmd,
   input  wire hscf_pkg::status_type status
);
   import hscf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SQR, S_SUM, S_SQRT, S_EVAL, S_MULK, S_CMP, S_NUM, S_DIV, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_SQR;
            end
         end
         S_SQR: begin
            cmd.square = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_MULK;
         end
         S_MULK: begin
            cmd.ke   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.num  = 1'b1;
            cnt_in   = '0;
            state_in = status.zero_force ? S_OUT : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### design/hscf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module hscf_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [hscf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [hscf_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic signed [hscf_pkg::POS_W-1:0]    pos_x,
   input  wire logic signed [hscf_pkg::POS_W-1:0]    pos_y,
   input  wire logic signed [hscf_pkg::POS_W-1:0]    pos_z,
   input  wire logic                                 just_activated,
   input  wire hscf_pkg::cmd_type                    cmd,
   output hscf_pkg::status_type                      status,
   output logic signed [hscf_pkg::FORCE_W-1:0]       force_x,
   output logic signed [hscf_pkg::FORCE_W-1:0]       force_y,
   output logic signed [hscf_pkg::FORCE_W-1:0]       force_z,
   output logic                                      inside_res,
   output logic                                      in_contact
);
   import hscf_pkg::*;

   // configuration
   logic [POS_W-1:0]  bias_ff [3];
   logic [RAD_W-1:0]  sph_r_ff, cur_r_ff;
   logic [K_W-1:0]    k_ff;
   logic [LIM_W-1:0]  lim_ff;
   logic              inside_ff, inside_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff[0] <= POS_W'(0);
         bias_ff[1] <= POS_W'(-200000);
         bias_ff[2] <= POS_W'(-700000);
         sph_r_ff   <= RAD_W'(70000);
         cur_r_ff   <= RAD_W'(10000);
         k_ff       <= K_W'(-4000);
         lim_ff     <= LIM_W'(40000);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BIAS_X:        bias_ff[0] <= csr_data[POS_W-1:0];
            REG_BIAS_Y:        bias_ff[1] <= csr_data[POS_W-1:0];
            REG_BIAS_Z:        bias_ff[2] <= csr_data[POS_W-1:0];
            REG_SPHERE_RADIUS: sph_r_ff   <= csr_data[RAD_W-1:0];
            REG_CURSOR_RADIUS: cur_r_ff   <= csr_data[RAD_W-1:0];
            REG_STIFFNESS:     k_ff       <= csr_data[K_W-1:0];
            REG_FORCE_LIMIT:   lim_ff     <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // working registers
   logic [DV_W-1:0]   dv_ff [3];
   logic [DV_W-1:0]   mag_ff [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic              ja_ff;
   logic [SQ_W-1:0]   n_ff;
   logic [SREM_W-1:0] srem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [E_W-1:0]    e_ff;
   logic              contact_ff;
   logic [KE_W-1:0]   ke_ff;
   logic [KE_W-1:0]   m_ff;
   logic              clamp_ff;
   logic [NUM_W-1:0]  num_ff [3];
   logic              neg_ff [3];
   logic [DEN_W-1:0]  den_ff;
   logic [DREM_W-1:0] drem_ff [3];
   logic [FORCE_W-1:0] f_ff [3];
   logic              out_inside_ff, out_contact_ff;

   logic [POS_W-1:0]  pos [3];
   assign pos[0] = pos_x;
   assign pos[1] = pos_y;
   assign pos[2] = pos_z;

   // sqrt step: two radicand bits per cycle
   logic [SREM_W-1:0] srem_sh, strial;
   assign srem_sh = {srem_ff[SREM_W-3:0], n_ff[SQ_W-1 -: 2]};
   assign strial  = {1'b0, root_ff, 2'b01};

   // penetration
   logic              inside_nx;
   logic [BASE_W-1:0] base;
   logic [E_W-1:0]    e_nx;
   logic              contact_nx;
   assign inside_nx = ja_ff ? (root_ff < ROOT_W'(sph_r_ff)) : inside_ff;
   assign base = inside_nx ? (BASE_W'(sph_r_ff) - BASE_W'(cur_r_ff))
                           : (BASE_W'(sph_r_ff) + BASE_W'(cur_r_ff));
   assign e_nx = {2'b00, root_ff} - {{(E_W-BASE_W){base[BASE_W-1]}}, base};
   assign contact_nx = inside_nx ? (!e_nx[E_W-1] && (e_nx != '0)) : e_nx[E_W-1];

   logic [MSEL_W-1:0] lim1000;
   logic [MSEL_W-1:0] msel;
   assign lim1000 = MSEL_W'(lim_ff) * MSEL_W'(MN_PER_UN);
   assign msel    = clamp_ff ? MSEL_W'(lim_ff) : m_ff[MSEL_W-1:0];

   assign status.zero_force = !contact_ff || (root_ff == '0);

   logic [DREM_W-1:0] drem_sh [3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         drem_sh[i] = {drem_ff[i][DREM_W-2:0], num_ff[i][NUM_W-1]};
   end

   assign inside_in = cmd.eval ? inside_nx : inside_ff;

   always_ff @(posedge clock) begin
      if (reset) inside_ff <= 1'b0;
      else       inside_ff <= inside_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         for (int i = 0; i < 3; i++)
            dv_ff[i] <= {pos[i][POS_W-1], pos[i]} + {bias_ff[i][POS_W-1], bias_ff[i]};
         ja_ff <= just_activated;
      end
      if (cmd.square) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= dv_ff[i][DV_W-1] ? (DV_W'(0) - dv_ff[i]) : dv_ff[i];
            sq_ff[i]  <= SQ_W'($signed(dv_ff[i]) * $signed(dv_ff[i]));
         end
      end
      if (cmd.sum) begin
         n_ff    <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         n_ff <= {n_ff[SQ_W-3:0], 2'b00};
         if (srem_sh >= strial) begin
            srem_ff <= srem_sh - strial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.eval) begin
         e_ff       <= e_nx;
         contact_ff <= contact_nx;
      end
      if (cmd.ke) begin
         ke_ff <= KE_W'($signed(k_ff) * $signed(e_ff));
      end
      if (cmd.cmp) begin
         m_ff     <= ke_ff[KE_W-1] ? (KE_W'(0) - ke_ff) : ke_ff;
         clamp_ff <= (ke_ff[KE_W-1] ? (KE_W'(0) - ke_ff) : ke_ff) > KE_W'(lim1000);
      end
      if (cmd.num) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i]  <= NUM_W'(msel) * NUM_W'(mag_ff[i]);
            neg_ff[i]  <= ke_ff[KE_W-1] != dv_ff[i][DV_W-1];
            drem_ff[i] <= '0;
         end
         den_ff <= clamp_ff ? DEN_W'(root_ff) : DEN_W'(root_ff) * DEN_W'(MN_PER_UN);
      end
      if (cmd.div_step) begin
         for (int i = 0; i < 3; i++) begin
            if (drem_sh[i] >= DREM_W'(den_ff)) begin
               drem_ff[i] <= drem_sh[i] - DREM_W'(den_ff);
               num_ff[i]  <= {num_ff[i][NUM_W-2:0], 1'b1};
            end else begin
               drem_ff[i] <= drem_sh[i];
               num_ff[i]  <= {num_ff[i][NUM_W-2:0], 1'b0};
            end
         end
      end
      if (cmd.out_load) begin
         for (int i = 0; i < 3; i++) begin
            if (status.zero_force)
               f_ff[i] <= '0;
            else if (neg_ff[i])
               f_ff[i] <= FORCE_W'(0) - num_ff[i][FORCE_W-1:0];
            else
               f_ff[i] <= num_ff[i][FORCE_W-1:0];
         end
         out_inside_ff  <= inside_ff;
         out_contact_ff <= contact_ff;
      end
   end

   assign force_x    = f_ff[0];
   assign force_y    = f_ff[1];
   assign force_z    = f_ff[2];
   assign inside_res = out_inside_ff;
   assign in_contact = out_contact_ff;

endmodule
`default_nettype wire

### design/haptic_sphere_contact_force_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sphere contact force unit: one request word in, one response word out. Each
// word passes through 3 setup steps, 23 square-root iterations, 4 evaluation
// steps and 51 divide iterations before its response is valid; the divide is
// skipped when the force is zero. The root is bit-serial and the three divides
// run in parallel as restoring dividers. Requests are taken only while no word is
// in flight; a finished response waits in its output register and does not
// hold off the next request. CSR writes are taken any cycle but must only be
// issued while the unit is idle.
module haptic_sphere_contact_force_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [hscf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [hscf_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [hscf_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic signed [hscf_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic signed [hscf_pkg::POS_W-1:0]    req_pos_z,
   input  wire logic                                 req_just_activated,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [hscf_pkg::FORCE_W-1:0]       rsp_force_x,
   output logic signed [hscf_pkg::FORCE_W-1:0]       rsp_force_y,
   output logic signed [hscf_pkg::FORCE_W-1:0]       rsp_force_z,
   output logic                                      rsp_inside_res,
   output logic                                      rsp_in_contact
);
   import hscf_pkg::*;

   cmd_type    cmd;
   status_type status;

   hscf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   hscf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pos_x          (req_pos_x),
      .pos_y          (req_pos_y),
      .pos_z          (req_pos_z),
      .just_activated (req_just_activated),
      .cmd            (cmd),
      .status         (status),
      .force_x        (rsp_force_x),
      .force_y        (rsp_force_y),
      .force_z        (rsp_force_z),
      .inside_res     (rsp_inside_res),
      .in_contact     (rsp_in_contact)
   );

endmodule
`default_nettype wire

### sim/haptic_sphere_contact_force_unit_test.sv
`timescale 1ns / 1ps
module haptic_sphere_contact_force_unit_test;
   import hscf_pkg::*;

   localparam int RANDOM_WORDS = 1250;
   localparam int SETTLE_CYCLES = 200;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic req_valid;
   logic req_stall;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic req_just_activated;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [FORCE_W-1:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic rsp_inside_res;
   logic rsp_in_contact;

   haptic_sphere_contact_force_unit DUT (.*);

   typedef struct packed {
      logic signed [FORCE_W-1:0] fx;
      logic signed [FORCE_W-1:0] fy;
      logic signed [FORCE_W-1:0] fz;
      logic in_sphere;
      logic contact;
   } force_word_type;

   typedef struct {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic act;
      logic known;
      force_word_type exp_word;
   } stim_row_type;

   // shadow registers
   logic signed [POS_W-1:0] bias_q [3];
   logic [RAD_W-1:0] sphere_r_q, cursor_r_q;
   logic signed [K_W-1:0] stiff_q;
   logic [LIM_W-1:0] limit_q;
   logic inside_q;

   force_word_type pending_forces [$];
   int fail_count;
   logic drain_mode;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("haptic_sphere_contact_force_unit: mismatch");
      $finish;
   end

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic force_word_type predict_force(logic signed [POS_W-1:0] px,
         logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz, logic act);
      longint dv [3];
      longint unsigned sq, d, m, lim1000, a, q;
      longint e, ke, k, rs, rc;
      logic contact, neg;
      longint f [3];
      force_word_type w;
      dv[0] = longint'(px) + longint'(bias_q[0]);
      dv[1] = longint'(py) + longint'(bias_q[1]);
      dv[2] = longint'(pz) + longint'(bias_q[2]);
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         a = (dv[i] < 0) ? -dv[i] : dv[i];
         sq += a * a;
      end
      d = root_floor(sq);
      rs = longint'(sphere_r_q);
      rc = longint'(cursor_r_q);
      k = longint'(stiff_q);
      if (act) inside_q = longint'(d) < rs;
      e = longint'(d) - (inside_q ? rs - rc : rs + rc);
      contact = inside_q ? (e > 0) : (e < 0);
      f = '{0, 0, 0};
      if (contact && d != 0) begin
         ke = k * e;
         m = (ke < 0) ? -ke : ke;
         lim1000 = longint'(limit_q) * 1000;
         for (int i = 0; i < 3; i++) begin
            a = (dv[i] < 0) ? -dv[i] : dv[i];
            neg = (ke < 0) != (dv[i] < 0);
            if (m > lim1000) q = (longint'(limit_q) * a) / d;
            else q = (m * a) / (1000 * d);
            f[i] = neg ? -longint'(q) : longint'(q);
         end
      end
      w.fx = f[0][FORCE_W-1:0];
      w.fy = f[1][FORCE_W-1:0];
      w.fz = f[2][FORCE_W-1:0];
      w.in_sphere = inside_q;
      w.contact = contact;
      return w;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_BIAS_X: bias_q[0] = value[POS_W-1:0];
         REG_BIAS_Y: bias_q[1] = value[POS_W-1:0];
         REG_BIAS_Z: bias_q[2] = value[POS_W-1:0];
         REG_SPHERE_RADIUS: sphere_r_q = value[RAD_W-1:0];
         REG_CURSOR_RADIUS: cursor_r_q = value[RAD_W-1:0];
         REG_STIFFNESS: stiff_q = value[K_W-1:0];
         REG_FORCE_LIMIT: limit_q = value[LIM_W-1:0];
         default: ;
      endcase
   endtask

   // waits until every expected response word has arrived, then lets the unit settle
   task automatic wait_idle();
      while (pending_forces.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   int gap_left = 0;
   int burst_left = 0;

   task automatic send_word(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
         logic signed [POS_W-1:0] pz, logic act, logic known, force_word_type exp_word);
      force_word_type w;
      if (burst_left == 0) begin
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 120);
         burst_left = $urandom_range(1, 12);
      end
      repeat (gap_left) @(negedge clock);
      gap_left = 0;
      burst_left--;
      w = predict_force(px, py, pz, act);
      if (known && w !== exp_word) begin
         $error("table row: expected %p, predicted %p", exp_word, w);
         fail_count++;
      end
      req_valid = 1'b1;
      req_pos_x = px;
      req_pos_y = py;
      req_pos_z = pz;
      req_just_activated = act;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_forces.push_back(w);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver stall pattern
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (drain_mode) rsp_stall <= 1'b0;
      else if (stall_phase[9:8] == 2'd0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      force_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_forces.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            e = pending_forces.pop_front();
            if (rsp_force_x !== e.fx) begin
               $error("force_x expected %0d actual %0d", e.fx, rsp_force_x);
               fail_count++;
            end
            if (rsp_force_y !== e.fy) begin
               $error("force_y expected %0d actual %0d", e.fy, rsp_force_y);
               fail_count++;
            end
            if (rsp_force_z !== e.fz) begin
               $error("force_z expected %0d actual %0d", e.fz, rsp_force_z);
               fail_count++;
            end
            if (rsp_inside_res !== e.in_sphere) begin
               $error("inside_res expected %0d actual %0d", e.in_sphere, rsp_inside_res);
               fail_count++;
            end
            if (rsp_in_contact !== e.contact) begin
               $error("in_contact expected %0d actual %0d", e.contact, rsp_in_contact);
               fail_count++;
            end
         end
      end
   end

   function automatic longint rand_signed(longint lo, longint hi);
      return lo + longint'($urandom_range(0, hi - lo));
   endfunction

   task automatic random_setting(int style);
      case (style)
         0: begin
            write_reg(REG_BIAS_X, 0);
            write_reg(REG_BIAS_Y, -200000);
            write_reg(REG_BIAS_Z, -700000);
            write_reg(REG_SPHERE_RADIUS, 70000);
            write_reg(REG_CURSOR_RADIUS, 10000);
            write_reg(REG_STIFFNESS, -4000);
            write_reg(REG_FORCE_LIMIT, 40000);
         end
         1: begin
            write_reg(REG_BIAS_X, 2000000);
            write_reg(REG_BIAS_Y, -2000000);
            write_reg(REG_BIAS_Z, 2000000);
            write_reg(REG_SPHERE_RADIUS, 1000000);
            write_reg(REG_CURSOR_RADIUS, 1000000);
            write_reg(REG_STIFFNESS, 100000);
            write_reg(REG_FORCE_LIMIT, 200000);
         end
         2: begin
            write_reg(REG_BIAS_X, -2000000);
            write_reg(REG_BIAS_Y, 0);
            write_reg(REG_BIAS_Z, -2000000);
            write_reg(REG_SPHERE_RADIUS, 0);
            write_reg(REG_CURSOR_RADIUS, 0);
            write_reg(REG_STIFFNESS, -100000);
            write_reg(REG_FORCE_LIMIT, 0);
         end
         default: begin
            // raw bit patterns for every register but the stiffness, drawn from -100000 to 100000
            write_reg(REG_BIAS_X, $urandom());
            write_reg(REG_BIAS_Y, $urandom());
            write_reg(REG_BIAS_Z, $urandom());
            write_reg(REG_SPHERE_RADIUS, $urandom());
            write_reg(REG_CURSOR_RADIUS, $urandom());
            write_reg(REG_STIFFNESS, rand_signed(-100000, 100000));
            write_reg(REG_FORCE_LIMIT, $urandom());
            if ($urandom_range(0, 1)) begin
               write_reg(REG_BIAS_X, rand_signed(-100000, 100000));
               write_reg(REG_BIAS_Y, rand_signed(-100000, 100000));
               write_reg(REG_BIAS_Z, rand_signed(-100000, 100000));
               write_reg(REG_SPHERE_RADIUS, $urandom_range(0, 200000));
               write_reg(REG_CURSOR_RADIUS, $urandom_range(0, 60000));
            end
         end
      endcase
   endtask

   initial begin
      stim_row_type table_rows [$];
      stim_row_type row;
      force_word_type zero_out, zero_in;
      longint r, s, span;
      logic signed [POS_W-1:0] px, py, pz;
      fail_count = 0;
      drain_mode = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_just_activated = 1'b0;
      rsp_stall = 1'b0;
      bias_q = '{0, -200000, -700000};
      sphere_r_q = 70000;
      cursor_r_q = 10000;
      stiff_q = -4000;
      limit_q = 40000;
      inside_q = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      zero_out = '{fx: 0, fy: 0, fz: 0, in_sphere: 1'b0, contact: 1'b0};
      zero_in = '{fx: 0, fy: 0, fz: 0, in_sphere: 1'b1, contact: 1'b0};
      // reset settings, cursor at sphere centre: d = 0
      table_rows.push_back('{0, 200000, 700000, 1'b0, 1'b1,
         '{fx: 0, fy: 0, fz: 0, in_sphere: 1'b0, contact: 1'b1}});
      table_rows.push_back('{0, 200000, 700000, 1'b1, 1'b1, zero_in});
      table_rows.push_back('{30000, 200000, 700000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{65000, 200000, 700000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{0, 265000, 700000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{0, 200000, 635000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{500000, 200000, 700000, 1'b1, 1'b1, zero_out});
      table_rows.push_back('{75000, 200000, 700000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{-75000, 200000, 700000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{45000, 245000, 745000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{2000000, 2000000, 2000000, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{-2000000, -2000000, -2000000, 1'b1, 1'b0, zero_out});
      table_rows.push_back('{-2097152, 2097151, -2097152, 1'b0, 1'b0, zero_out});
      table_rows.push_back('{2097151, -2097152, 2097151, 1'b1, 1'b0, zero_out});
      table_rows.push_back('{10000, 200000, 700000, 1'b1, 1'b0, zero_out});
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_word(row.px, row.py, row.pz, row.act, row.known, row.exp_word);
      end

      // fixed then random settings; zero stiffness, zero limit, large cursor radius
      for (int phase = 0; phase < 14; phase++) begin
         wait_idle();
         random_setting(phase < 3 ? phase : 3);
         if (phase == 4) write_reg(REG_STIFFNESS, 0);
         if (phase == 5) write_reg(REG_FORCE_LIMIT, 0);
         if (phase == 6) write_reg(REG_CURSOR_RADIUS, 1000000);
         // stray index is ignored
         csr_wr_en = 1'b1;
         csr_index = 3'd7;
         csr_data = $urandom();
         @(negedge clock);
         csr_wr_en = 1'b0;
         for (int n = 0; n < RANDOM_WORDS / 14; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               px = $urandom();
               py = $urandom();
               pz = $urandom();
            end else begin
               // aim near the surface so contact is frequent
               r = longint'(sphere_r_q);
               s = longint'(cursor_r_q);
               span = r + s + 20000;
               px = rand_signed(-span, span) - bias_q[0];
               py = rand_signed(-span, span) - bias_q[1];
               pz = rand_signed(-span, span) - bias_q[2];
            end
            send_word(px, py, pz, ($urandom_range(0, 7) == 0), 1'b0, zero_out);
         end
      end

      drain_mode = 1'b1;
      for (int t = 0; t < 100000 && pending_forces.size() != 0; t++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_forces.size() == 0)
         $display("haptic_sphere_contact_force_unit: match");
      else
         $display("haptic_sphere_contact_force_unit: mismatch");
      $finish;
   end

endmodule

### files.f
design/hscf_pkg.sv
design/hscf_ctrl.sv
design/hscf_datapath.sv
design/haptic_sphere_contact_force_unit.sv
sim/haptic_sphere_contact_force_unit_test.sv
